FILE: sv/kss_pkg.sv
package kss_pkg;

    // payload and configuration widths
    localparam int OFFSET_W   = 8;
    localparam int VALUE_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    // compare width: holds any position plus offset
    localparam int CMP_W      = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE = 2'd1;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic issue;   // latch offset and read both store entries
        logic commit;  // write back, advance position, load output word
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } dp_status_t;

endpackage

FILE: sv/kss_if.sv
// input channel: one random offset per word
interface kss_in_if;
    logic                         valid;
    logic                         ready;
    logic [kss_pkg::OFFSET_W-1:0] random_offset;

    modport source (output valid, output random_offset, input ready);
    modport sink   (input valid, input random_offset, output ready);
endinterface

// output channel: one pick per word
interface kss_out_if;
    logic                        valid;
    logic                        ready;
    logic [kss_pkg::VALUE_W-1:0] picked_value;
    logic                        last_pick;
    logic                        bad_offset;

    modport source (output valid, output picked_value, output last_pick,
                    output bad_offset, input ready);
    modport sink   (input valid, input picked_value, input last_pick,
                    input bad_offset, output ready);
endinterface

FILE: sv/kss_ctrl.sv
module kss_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    input  kss_pkg::dp_status_t status,
    output kss_pkg::dp_cmd_t    cmd
);

    kss_pkg::ctrl_state_t state_reg;
    kss_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.issue  = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            kss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.issue  = 1'b1;
                    state_next = kss_pkg::ST_READ;
                end
            end
            kss_pkg::ST_READ:
            begin
                // commit once the output register has room
                if (!status.out_full || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = kss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/kss_dp.sv
module kss_dp
#(
    parameter int SET_CAPACITY = 256
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [kss_pkg::OFFSET_W-1:0]     random_offset,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [kss_pkg::VALUE_W-1:0]      picked_value,
    output logic                             last_pick,
    output logic                             bad_offset,
    input  logic                             cfg_we,
    input  logic [kss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  kss_pkg::dp_cmd_t                 cmd,
    output kss_pkg::dp_status_t              status
);

    // largest usable set: limited by capacity and by the size register
    localparam int MAX_N = (SET_CAPACITY < 511) ? SET_CAPACITY : 511;
    localparam int IDX_W = $clog2(MAX_N);
    localparam int NW    = $clog2(MAX_N + 1);
    localparam int DEPTH = 1 << IDX_W;
    localparam int CW    = kss_pkg::CMP_W;
    localparam int VW    = kss_pkg::VALUE_W;
    localparam int DW    = kss_pkg::CFG_DATA_W;

    logic [DW-1:0]    set_size_reg;
    logic [DW-1:0]    subset_size_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [DEPTH-1:0] vld_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             bad_reg;
    logic [VW-1:0]    rd_a_reg;
    logic [VW-1:0]    rd_b_reg;
    logic [VW-1:0]    perm_mem [DEPTH];
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [VW-1:0]    out_value_reg;
    logic             out_last_reg;
    logic             out_bad_reg;

    logic [DW-1:0]    n_floor;
    logic [NW-1:0]    n_eff;
    logic [DW-1:0]    k_eff;
    logic [CW-1:0]    picks;
    logic [CW-1:0]    off_sum;
    logic [CW-1:0]    pos_inc;
    logic             last;
    logic [VW-1:0]    val;
    logic [VW-1:0]    cur;
    logic             cfg_hit;
    logic             good_commit;

    // effective sizes
    always_comb
    begin
        n_floor = (set_size_reg == '0) ? DW'(1) : set_size_reg;
        n_eff   = (n_floor > DW'(MAX_N)) ? NW'(MAX_N) : NW'(n_floor);
        k_eff   = (subset_size_reg == '0) ? DW'(1) : subset_size_reg;
        picks   = (CW'(k_eff) < CW'(n_eff)) ? CW'(k_eff) : CW'(n_eff);
    end

    // range check on the incoming offset
    assign off_sum = CW'(pos_reg) + CW'(random_offset);

    // slot values: unwritten slots read as their own index
    assign val     = vld_reg[idx_reg] ? rd_a_reg : VW'(idx_reg);
    assign cur     = vld_reg[pos_reg] ? rd_b_reg : VW'(pos_reg);
    assign pos_inc = CW'(pos_reg) + CW'(1);
    assign last    = (pos_inc >= picks);

    assign cfg_hit     = cfg_we && ((cfg_index == kss_pkg::REG_SET_SIZE) ||
                                    (cfg_index == kss_pkg::REG_SUBSET_SIZE));
    assign good_commit = cmd.commit && !bad_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg    <= DW'(1);
            subset_size_reg <= DW'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == kss_pkg::REG_SET_SIZE)
            begin
                set_size_reg <= cfg_data;
            end
            if (cfg_index == kss_pkg::REG_SUBSET_SIZE)
            begin
                subset_size_reg <= cfg_data;
            end
        end
    end

    // draw position and written marks; a size register write or the last pick restarts the draw
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vld_reg <= '0;
        end
        else if (cfg_hit)
        begin
            pos_reg <= '0;
            vld_reg <= '0;
        end
        else if (good_commit)
        begin
            if (last)
            begin
                pos_reg <= '0;
                vld_reg <= '0;
            end
            else
            begin
                pos_reg          <= pos_inc[IDX_W-1:0];
                vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // latched offset result
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            idx_reg <= off_sum[IDX_W-1:0];
            bad_reg <= (off_sum >= CW'(n_eff));
        end
    end

    // permutation store: two registered reads at issue, one write at a good commit
    always_ff @(posedge clk)
    begin
        if (good_commit)
        begin
            perm_mem[idx_reg] <= cur;
        end
        if (cmd.issue)
        begin
            rd_a_reg <= perm_mem[off_sum[IDX_W-1:0]];
            rd_b_reg <= perm_mem[pos_reg];
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_value_reg <= bad_reg ? '0 : val;
            out_last_reg  <= bad_reg ? 1'b0 : last;
            out_bad_reg   <= bad_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign picked_value    = out_value_reg;
    assign last_pick       = out_last_reg;
    assign bad_offset      = out_bad_reg;
    assign status.out_full = out_valid_reg;

    // position stays inside the set
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(pos_reg) < CW'(n_eff))
        else $error("draw position outside set");

    // a commit never overwrites a word still waiting
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

    // a rejected offset leaves the draw untouched
    a_bad_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && bad_reg && !cfg_we) |=> ($stable(pos_reg) && $stable(vld_reg)))
        else $error("bad offset changed draw state");

    // a good pick that is not last advances the position by one
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (good_commit && !last && !cfg_we) |=> (pos_reg == $past(pos_reg) + IDX_W'(1)))
        else $error("position did not advance");

endmodule

FILE: sv/k_subset_sampler.sv
// Draws subset_size distinct values out of 0..set_size-1 by a partial shuffle: each
// input word carries one random offset, which must be below set_size minus the
// current draw position; the output word carries the picked value, a flag on the
// last pick of the draw and a flag for an out-of-range offset (then the value is
// zero and nothing changes). A draw ends after min(subset_size, set_size) picks
// and the next word starts a new draw; any write to either size register also
// restarts the draw. For each pick, the accept cycle reads both store entries from
// the registered-read permutation memory, and the commit step, once the output
// register has room, writes the moved element back and loads the output register;
// no new word is taken before that commit. A new input word is taken while the
// previous result still sits in the output register. The written marks are
// flip-flops cleared together: no clearing pass after reset or between draws.
module k_subset_sampler
#(
    parameter int SET_CAPACITY = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    kss_in_if.sink                         in_ch,
    kss_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [kss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kss_pkg::CFG_DATA_W-1:0] cfg_data
);

    kss_pkg::dp_cmd_t    cmd;
    kss_pkg::dp_status_t status;

    // controller
    kss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath with store and output register
    kss_dp #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .random_offset (in_ch.random_offset),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .picked_value  (out_ch.picked_value),
        .last_pick     (out_ch.last_pick),
        .bad_offset    (out_ch.bad_offset),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
